/* hw/rtl/tre_pkg.sv */
package tre_pkg;

    // Fixed field widths
    localparam int VW    = 12;  // vertex coordinate
    localparam int OPW   = 2;   // operation code
    localparam int CH    = 8;   // one colour channel
    localparam int PIXW  = 3 * CH;
    localparam int DW    = 14;  // coordinate difference, room for box origin minus vertex
    localparam int PW    = 2 * DW;
    localparam int EW    = PW + 1;
    localparam int STEPW = 4;

    // Setup runs eight multiplies; the last subtract lands one step later
    localparam logic [STEPW-1:0] SETUP_LAST = 4'd8;

    typedef enum logic [OPW-1:0] {
        OP_CLEAR = 2'd0,
        OP_FILL  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_CLEAR,
        ST_SETUP,
        ST_CHECK,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } state_t;

    typedef logic signed [VW-1:0] coord_t;
    typedef logic signed [VW:0]   coord_wide_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [EW-1:0] edge_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic setup_step;
        logic scan_step;
        logic rd_issue;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic setup_last;
        logic area_zero;
        logic box_empty;
        logic scan_last;
    } status_t;

endpackage

/* hw/rtl/tre_ctrl.sv */
module tre_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tre_pkg::op_t     s_op,
    output logic             m_valid,
    input  logic             m_ready,
    output tre_pkg::cmd_t    cmd,
    input  tre_pkg::status_t sts
);
    import tre_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_WIPE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_WIPE: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_op)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_FILL:  state_next = ST_SETUP;
                        OP_READ:  state_next = ST_READ;
                        OP_NOP:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (sts.clr_last) state_next = ST_DONE;
            end
            ST_SETUP: begin
                if (sts.setup_last) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = (sts.area_zero || sts.box_empty) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.scan_last) state_next = ST_DONE;
            end
            ST_READ: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = (m_valid_reg && !m_ready);
        unique case (state_reg)
            ST_WIPE:  cmd.clr_step = 1'b1;
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_CLEAR: cmd.clr_step   = 1'b1;
            ST_SETUP: cmd.setup_step = 1'b1;
            ST_CHECK: cmd            = '0;
            ST_SCAN:  cmd.scan_step  = 1'b1;
            ST_READ:  cmd.rd_issue   = 1'b1;
            ST_DONE: begin
                cmd.out_load = slot_free;
                if (slot_free) m_valid_next = 1'b1;
            end
        endcase
    end

    a_fill_enters_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == OP_FILL) |=> state_reg == ST_SETUP)
        else $error("fill transfer did not start setup");

    a_check_resolves: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK |=> (state_reg == ST_SCAN || state_reg == ST_DONE))
        else $error("check state did not resolve");

    a_no_work_while_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.clr_step || cmd.scan_step || cmd.setup_step))
        else $error("datapath busy while ready");

    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && state_reg == ST_DONE) |=> state_reg == ST_DONE)
        else $error("result overwritten before transfer");

endmodule

/* hw/rtl/tre_datapath.sv */
module tre_datapath #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tre_pkg::cmd_t         cmd,
    output tre_pkg::status_t      sts,
    input  tre_pkg::op_t          in_op,
    input  logic signed [11:0]    in_x0,
    input  logic signed [11:0]    in_y0,
    input  logic signed [11:0]    in_x1,
    input  logic signed [11:0]    in_y1,
    input  logic signed [11:0]    in_x2,
    input  logic signed [11:0]    in_y2,
    input  logic [7:0]            in_red,
    input  logic [7:0]            in_green,
    input  logic [7:0]            in_blue,
    input  logic [5:0]            in_col,
    input  logic [4:0]            in_row,
    output logic [7:0]            out_red,
    output logic [7:0]            out_green,
    output logic [7:0]            out_blue,
    output logic                  out_degenerate
);
    import tre_pkg::*;

    localparam int CW    = (SCREEN_WIDTH  > 1) ? $clog2(SCREEN_WIDTH)  : 1;
    localparam int RW    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int AW    = CW + RW;
    localparam int DEPTH = 2 ** AW;

    localparam coord_wide_t XMAX  = coord_wide_t'(SCREEN_WIDTH - 1);
    localparam coord_wide_t YMAX  = coord_wide_t'(SCREEN_HEIGHT - 1);
    localparam logic [CW-1:0] XLAST = CW'(SCREEN_WIDTH - 1);
    localparam logic [RW-1:0] YLAST = RW'(SCREEN_HEIGHT - 1);

    function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
        coord_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
        coord_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Item registers
    op_t             op_reg;
    coord_t          x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic [PIXW-1:0] colour_reg;
    logic [CW-1:0]   lox_reg, hix_reg, px_reg;
    logic [RW-1:0]   loy_reg, hiy_reg, py_reg;
    logic            empty_reg;
    logic [AW-1:0]   rd_addr_reg;
    logic            rd_ok_reg;

    // Setup unit
    logic [STEPW-1:0] step_reg;
    prod_t            prod_reg, hold_reg, prod_next;
    edge_t            area_reg;
    edge_t            w_reg     [3];
    edge_t            w_row_reg [3];

    // Clear sweep and frame store
    logic [AW-1:0]   clr_addr_reg;
    logic [PIXW-1:0] frame_mem [DEPTH];
    logic [PIXW-1:0] rd_data_reg;
    logic [PIXW-1:0] pixel_reg;
    logic            degen_reg;

    // Bounding box from the incoming vertices
    coord_t        mnx, mxx, mny, mxy;
    logic          box_empty;
    logic [CW-1:0] lox_c, hix_c;
    logic [RW-1:0] loy_c, hiy_c;

    always_comb begin
        mnx = min3(in_x0, in_x1, in_x2);
        mxx = max3(in_x0, in_x1, in_x2);
        mny = min3(in_y0, in_y1, in_y2);
        mxy = max3(in_y0, in_y1, in_y2);
        box_empty = (mxx < 0) || (coord_wide_t'(mnx) > XMAX)
                 || (mxy < 0) || (coord_wide_t'(mny) > YMAX);
        lox_c = (mnx < 0) ? '0 : mnx[CW-1:0];
        loy_c = (mny < 0) ? '0 : mny[RW-1:0];
        hix_c = (coord_wide_t'(mxx) > XMAX) ? XLAST : mxx[CW-1:0];
        hiy_c = (coord_wide_t'(mxy) > YMAX) ? YLAST : mxy[RW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg      <= in_op;
            x0_reg      <= in_x0;
            y0_reg      <= in_y0;
            x1_reg      <= in_x1;
            y1_reg      <= in_y1;
            x2_reg      <= in_x2;
            y2_reg      <= in_y2;
            colour_reg  <= {in_red, in_green, in_blue};
            lox_reg     <= lox_c;
            hix_reg     <= hix_c;
            loy_reg     <= loy_c;
            hiy_reg     <= hiy_c;
            empty_reg   <= box_empty;
            rd_addr_reg <= {RW'(in_row), CW'(in_col)};
            rd_ok_reg   <= (32'(in_col) < 32'(SCREEN_WIDTH))
                        && (32'(in_row) < 32'(SCREEN_HEIGHT));
        end
    end

    // Setup: one multiply per step, the edge value formed one step later.
    // Pair 0 is the doubled area, pairs 1..3 the edge functions at the box origin.
    diff_t         ax, ay, bx, by, cx, cy, opa, opb;
    diff_t         px0, py0;
    logic [1:0]    pair;
    logic [STEPW-1:0] prev;
    logic [1:0]    prev_pair;
    edge_t         edge_val;

    assign px0 = diff_t'(lox_reg);
    assign py0 = diff_t'(loy_reg);
    assign pair = step_reg[2:1];

    always_comb begin
        ax = diff_t'(x0_reg); ay = diff_t'(y0_reg);
        bx = diff_t'(x1_reg); by = diff_t'(y1_reg);
        cx = diff_t'(x2_reg); cy = diff_t'(y2_reg);
        case (pair)
            2'd1: begin
                ax = diff_t'(x1_reg); ay = diff_t'(y1_reg);
                bx = diff_t'(x2_reg); by = diff_t'(y2_reg);
                cx = px0;             cy = py0;
            end
            2'd2: begin
                ax = diff_t'(x2_reg); ay = diff_t'(y2_reg);
                bx = diff_t'(x0_reg); by = diff_t'(y0_reg);
                cx = px0;             cy = py0;
            end
            2'd3: begin
                cx = px0;             cy = py0;
            end
            default: ;
        endcase
        opa       = step_reg[0] ? (cy - ay) : (cx - ax);
        opb       = step_reg[0] ? (bx - ax) : (by - ay);
        prod_next = opa * opb;
    end

    assign prev      = step_reg - 1'b1;
    assign prev_pair = prev[2:1];
    assign edge_val  = edge_t'(hold_reg) - edge_t'(prod_reg);

    // Per-pixel increments of each edge function
    edge_t xinc [3];
    edge_t yinc [3];

    always_comb begin
        xinc[0] = edge_t'(y2_reg) - edge_t'(y1_reg);
        yinc[0] = edge_t'(x1_reg) - edge_t'(x2_reg);
        xinc[1] = edge_t'(y0_reg) - edge_t'(y2_reg);
        yinc[1] = edge_t'(x2_reg) - edge_t'(x0_reg);
        xinc[2] = edge_t'(y1_reg) - edge_t'(y0_reg);
        yinc[2] = edge_t'(x0_reg) - edge_t'(x1_reg);
    end

    logic covered, x_end, y_end;
    logic all_ge, all_le;

    always_comb begin
        all_ge = !w_reg[0][EW-1] && !w_reg[1][EW-1] && !w_reg[2][EW-1];
        all_le = (w_reg[0][EW-1] || w_reg[0] == '0)
              && (w_reg[1][EW-1] || w_reg[1] == '0)
              && (w_reg[2][EW-1] || w_reg[2] == '0);
        covered = all_ge || all_le;
        x_end   = (px_reg == hix_reg);
        y_end   = (py_reg == hiy_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            step_reg <= '0;
            px_reg   <= lox_c;
            py_reg   <= loy_c;
        end else if (cmd.setup_step) begin
            step_reg <= step_reg + 1'b1;
            if (step_reg != SETUP_LAST) prod_reg <= prod_next;
            if (step_reg != '0) begin
                if (!prev[0]) begin
                    hold_reg <= prod_reg;
                end else if (prev_pair == 2'd0) begin
                    area_reg <= edge_val;
                end else begin
                    w_reg[prev_pair - 2'd1]     <= edge_val;
                    w_row_reg[prev_pair - 2'd1] <= edge_val;
                end
            end
        end else if (cmd.scan_step) begin
            if (x_end) begin
                px_reg <= lox_reg;
                py_reg <= py_reg + 1'b1;
                for (int e = 0; e < 3; e++) begin
                    w_row_reg[e] <= w_row_reg[e] + yinc[e];
                    w_reg[e]     <= w_row_reg[e] + yinc[e];
                end
            end else begin
                px_reg <= px_reg + 1'b1;
                for (int e = 0; e < 3; e++) begin
                    w_reg[e] <= w_reg[e] + xinc[e];
                end
            end
        end
    end

    // Clear sweep address; a full sweep wraps back to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Frame store: one write port, one registered read port
    logic            we;
    logic [AW-1:0]   waddr;
    logic [PIXW-1:0] wdata;

    always_comb begin
        we    = cmd.clr_step || (cmd.scan_step && covered);
        waddr = cmd.clr_step ? clr_addr_reg : {py_reg, px_reg};
        wdata = cmd.clr_step ? '0 : colour_reg;
    end

    always_ff @(posedge aclk) begin
        if (we) frame_mem[waddr] <= wdata;
        if (cmd.rd_issue) rd_data_reg <= frame_mem[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            pixel_reg <= (op_reg == OP_READ && rd_ok_reg) ? rd_data_reg : '0;
            degen_reg <= (op_reg == OP_FILL) && (area_reg == '0);
        end
    end

    assign out_red        = pixel_reg[PIXW-1 -: CH];
    assign out_green      = pixel_reg[CH +: CH];
    assign out_blue       = pixel_reg[CH-1:0];
    assign out_degenerate = degen_reg;

    assign sts.clr_last   = &clr_addr_reg;
    assign sts.setup_last = (step_reg == SETUP_LAST);
    assign sts.area_zero  = (area_reg == '0);
    assign sts.box_empty  = empty_reg;
    assign sts.scan_last  = x_end && y_end;

    a_scan_in_box: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (px_reg >= lox_reg && px_reg <= hix_reg
                           && py_reg >= loy_reg && py_reg <= hiy_reg))
        else $error("scan left the bounding box");

    a_scan_needs_area: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (area_reg != '0 && !empty_reg))
        else $error("scan of a degenerate or empty triangle");

    a_non_read_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && op_reg != OP_READ) |=> pixel_reg == '0)
        else $error("colour returned for a non-read item");

endmodule

/* hw/rtl/triangle_edge_rasterizer.sv */
// Channel   Direction  Ports                                      Transfer when
// ------    ---------  -----------------------------------------  ------------------
// s_        in         s_operation, s_vert*_x/y, s_fill_*, s_read_*  s_valid & s_ready
// m_        out        m_pixel_red/green/blue, m_degenerate        m_valid & m_ready
//
// Per item: a clear sweeps every address of the store, a read fetches one word,
//   an unused operation goes straight to its result, and a fill runs setup and
//   then walks the clamped bounding box one pixel per cycle (no walk when the area
//   is zero or the box lies off screen), as the frame store has a single write port.
// Reset: synchronous, active low; afterwards a clearing pass writes black to all
//   2^(clog2(W)+clog2(H)) words of the store (2048 at 64 by 32), with s_ready low.
// Stalls: a finished result waits in the output register; the next item is taken
//   meanwhile, and its own result holds in DONE until the register frees up.
module triangle_edge_rasterizer #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic signed [11:0] s_vert0_x,
    input  logic signed [11:0] s_vert0_y,
    input  logic signed [11:0] s_vert1_x,
    input  logic signed [11:0] s_vert1_y,
    input  logic signed [11:0] s_vert2_x,
    input  logic signed [11:0] s_vert2_y,
    input  logic [7:0]         s_fill_red,
    input  logic [7:0]         s_fill_green,
    input  logic [7:0]         s_fill_blue,
    input  logic [5:0]         s_read_col,
    input  logic [4:0]         s_read_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_pixel_red,
    output logic [7:0]         m_pixel_green,
    output logic [7:0]         m_pixel_blue,
    output logic               m_degenerate
);
    import tre_pkg::*;

    cmd_t    cmd;
    status_t sts;
    op_t     op;

    // Decode the operation once; every 2-bit code is a defined member
    assign op = op_t'(s_operation);

    // Sequencer: wipe after reset, then one transfer at a time
    tre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Setup multiplier, edge walk, frame store and result register
    tre_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_op          (op),
        .in_x0          (s_vert0_x),
        .in_y0          (s_vert0_y),
        .in_x1          (s_vert1_x),
        .in_y1          (s_vert1_y),
        .in_x2          (s_vert2_x),
        .in_y2          (s_vert2_y),
        .in_red         (s_fill_red),
        .in_green       (s_fill_green),
        .in_blue        (s_fill_blue),
        .in_col         (s_read_col),
        .in_row         (s_read_row),
        .out_red        (m_pixel_red),
        .out_green      (m_pixel_green),
        .out_blue       (m_pixel_blue),
        .out_degenerate (m_degenerate)
    );

endmodule

/* verif/tb.sv */
module tb;
    import tre_pkg::*;

    localparam int SCR_W       = 64;
    localparam int SCR_H       = 32;
    localparam int TAIL_CYCLES = 40;
    localparam int SHOW_LIMIT  = 10;

    // One command as the input channel carries it
    typedef struct {
        op_t        op;
        coord_t     v0x, v0y, v1x, v1y, v2x, v2y;
        logic [7:0] red, green, blue;
        logic [5:0] col;
        logic [4:0] row;
    } raster_cmd_t;

    // One answer as the result channel carries it
    typedef struct {
        logic [7:0] red, green, blue;
        logic       degen;
    } pixel_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation  = '0;
    logic signed [11:0] s_vert0_x    = '0;
    logic signed [11:0] s_vert0_y    = '0;
    logic signed [11:0] s_vert1_x    = '0;
    logic signed [11:0] s_vert1_y    = '0;
    logic signed [11:0] s_vert2_x    = '0;
    logic signed [11:0] s_vert2_y    = '0;
    logic [7:0]         s_fill_red   = '0;
    logic [7:0]         s_fill_green = '0;
    logic [7:0]         s_fill_blue  = '0;
    logic [5:0]         s_read_col   = '0;
    logic [4:0]         s_read_row   = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_pixel_red;
    logic [7:0]         m_pixel_green;
    logic [7:0]         m_pixel_blue;
    logic               m_degenerate;

    // Shadow copy of the frame and the answers still owed by the block
    logic [23:0] frame_px [SCR_W*SCR_H];
    pixel_t      owed_pixels [$];

    // Last painted box, used to aim reads at freshly written pixels
    bit  box_ok;
    int  box_lox, box_hix, box_loy, box_hiy;

    // Drop all idling on both channels while set
    bit  calm;

    int  err_count;
    int  n_results, n_clear, n_fill, n_degen, n_read, n_nop;

    triangle_edge_rasterizer #(
        .SCREEN_WIDTH (SCR_W),
        .SCREEN_HEIGHT(SCR_H)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_vert0_x    (s_vert0_x),
        .s_vert0_y    (s_vert0_y),
        .s_vert1_x    (s_vert1_x),
        .s_vert1_y    (s_vert1_y),
        .s_vert2_x    (s_vert2_x),
        .s_vert2_y    (s_vert2_y),
        .s_fill_red   (s_fill_red),
        .s_fill_green (s_fill_green),
        .s_fill_blue  (s_fill_blue),
        .s_read_col   (s_read_col),
        .s_read_row   (s_read_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_red  (m_pixel_red),
        .m_pixel_green(m_pixel_green),
        .m_pixel_blue (m_pixel_blue),
        .m_degenerate (m_degenerate)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow rasterizer
    // ------------------------------------------------------------------

    // Edge function: sign tells which side of a->b the point c lies on
    function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy);
        return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
    endfunction

    function automatic longint min3(longint a, longint b, longint c);
        longint m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic longint max3(longint a, longint b, longint c);
        longint m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Apply one accepted command to the shadow frame and queue its answer
    task automatic paint_model(raster_cmd_t c);
        pixel_t      res;
        longint      x0, y0, x1, y1, x2, y2;
        longint      lox, hix, loy, hiy;
        longint      w0, w1, w2;
        logic [23:0] colour;
        res.red   = '0;
        res.green = '0;
        res.blue  = '0;
        res.degen = 1'b0;
        case (c.op)
            OP_CLEAR: begin
                foreach (frame_px[i]) frame_px[i] = '0;
                box_ok = 1'b0;
                n_clear++;
            end
            OP_FILL: begin
                n_fill++;
                x0 = c.v0x;  y0 = c.v0y;
                x1 = c.v1x;  y1 = c.v1y;
                x2 = c.v2x;  y2 = c.v2y;
                colour = {c.red, c.green, c.blue};
                lox = min3(x0, x1, x2);
                hix = max3(x0, x1, x2);
                loy = min3(y0, y1, y2);
                hiy = max3(y0, y1, y2);
                if (lox < 0) lox = 0;
                if (loy < 0) loy = 0;
                if (hix > SCR_W - 1) hix = SCR_W - 1;
                if (hiy > SCR_H - 1) hiy = SCR_H - 1;
                if (edge_fn(x0, y0, x1, y1, x2, y2) == 0) begin
                    // zero area: skip even a line that crosses pixels
                    res.degen = 1'b1;
                    n_degen++;
                end else begin
                    for (longint py = loy; py <= hiy; py++) begin
                        for (longint px = lox; px <= hix; px++) begin
                            w0 = edge_fn(x1, y1, x2, y2, px, py);
                            w1 = edge_fn(x2, y2, x0, y0, px, py);
                            w2 = edge_fn(x0, y0, x1, y1, px, py);
                            if ((w0 >= 0 && w1 >= 0 && w2 >= 0) ||
                                (w0 <= 0 && w1 <= 0 && w2 <= 0))
                                frame_px[py * SCR_W + px] = colour;
                        end
                    end
                    if (lox <= hix && loy <= hiy) begin
                        box_ok  = 1'b1;
                        box_lox = int'(lox);
                        box_hix = int'(hix);
                        box_loy = int'(loy);
                        box_hiy = int'(hiy);
                    end
                end
            end
            OP_READ: begin
                n_read++;
                if (c.col < SCR_W && c.row < SCR_H)
                    {res.red, res.green, res.blue} = frame_px[c.row * SCR_W + c.col];
            end
            default: n_nop++;
        endcase
        owed_pixels.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Command builders
    // ------------------------------------------------------------------

    function automatic raster_cmd_t make_fill(int x0, int y0, int x1, int y1, int x2, int y2,
                                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        raster_cmd_t c;
        c.op  = OP_FILL;
        c.v0x = coord_t'(x0);  c.v0y = coord_t'(y0);
        c.v1x = coord_t'(x1);  c.v1y = coord_t'(y1);
        c.v2x = coord_t'(x2);  c.v2y = coord_t'(y2);
        c.red = r;  c.green = g;  c.blue = b;
        c.col = '0;  c.row = '0;
        return c;
    endfunction

    function automatic raster_cmd_t make_read(int col, int row);
        raster_cmd_t c;
        c = make_fill(0, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00);
        c.op  = OP_READ;
        c.col = 6'(col);
        c.row = 5'(row);
        return c;
    endfunction

    function automatic coord_t rnd_coord(int lo, int hi);
        return coord_t'(lo + int'($urandom_range(hi - lo)));
    endfunction

    // Random command: mostly small fills and reads, with some clears, unused
    // operations and whole-screen, zero-area and fully random fills mixed in
    function automatic raster_cmd_t random_cmd();
        raster_cmd_t c;
        int          pick, kind, cx, cy, dx, dy, k;
        c.op    = OP_READ;
        c.v0x   = coord_t'($urandom);  c.v0y = coord_t'($urandom);
        c.v1x   = coord_t'($urandom);  c.v1y = coord_t'($urandom);
        c.v2x   = coord_t'($urandom);  c.v2y = coord_t'($urandom);
        c.red   = 8'($urandom);
        c.green = 8'($urandom);
        c.blue  = 8'($urandom);
        c.col   = 6'($urandom);
        c.row   = 5'($urandom);
        pick = $urandom_range(99);
        if (pick < 4) begin
            c.op = OP_CLEAR;
        end else if (pick < 8) begin
            c.op = OP_NOP;
        end else if (pick < 50) begin
            c.op = OP_FILL;
            kind = $urandom_range(99);
            if (kind < 6) begin
                // keep the fully random vertices: every coordinate bit toggles
            end else if (kind < 16) begin
                c.v0x = rnd_coord(-20, 83);  c.v0y = rnd_coord(-20, 51);
                c.v1x = rnd_coord(-20, 83);  c.v1y = rnd_coord(-20, 51);
                c.v2x = rnd_coord(-20, 83);  c.v2y = rnd_coord(-20, 51);
            end else if (kind < 24) begin
                // collinear vertices, sometimes all on one point
                cx = int'($urandom_range(79)) - 8;
                cy = int'($urandom_range(47)) - 8;
                dx = int'($urandom_range(8)) - 4;
                dy = int'($urandom_range(8)) - 4;
                k  = int'($urandom_range(5)) - 2;
                c.v0x = coord_t'(cx);           c.v0y = coord_t'(cy);
                c.v1x = coord_t'(cx + dx);      c.v1y = coord_t'(cy + dy);
                c.v2x = coord_t'(cx + k * dx);  c.v2y = coord_t'(cy + k * dy);
            end else begin
                cx = int'($urandom_range(79)) - 8;
                cy = int'($urandom_range(47)) - 8;
                c.v0x = rnd_coord(cx - 6, cx + 6);  c.v0y = rnd_coord(cy - 6, cy + 6);
                c.v1x = rnd_coord(cx - 6, cx + 6);  c.v1y = rnd_coord(cy - 6, cy + 6);
                c.v2x = rnd_coord(cx - 6, cx + 6);  c.v2y = rnd_coord(cy - 6, cy + 6);
            end
        end else if (box_ok && $urandom_range(1)) begin
            // aim at the last painted box to read back fresh pixels
            c.col = 6'($urandom_range(box_hix, box_lox));
            c.row = 5'($urandom_range(box_hiy, box_loy));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------

    // Drive one command and hold it until the transfer; called and left at a
    // rising edge with valid still high; it drops between commands only for a random gap
    task automatic push_command(raster_cmd_t c);
        bit took;
        if (!calm && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= c.op;
        s_vert0_x    <= c.v0x;
        s_vert0_y    <= c.v0y;
        s_vert1_x    <= c.v1x;
        s_vert1_y    <= c.v1y;
        s_vert2_x    <= c.v2x;
        s_vert2_y    <= c.v2y;
        s_fill_red   <= c.red;
        s_fill_green <= c.green;
        s_fill_blue  <= c.blue;
        s_read_col   <= c.col;
        s_read_row   <= c.row;
        // sample ready mid-cycle, away from the edge where everything moves
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        paint_model(c);
    endtask

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------

    // Stall the result channel about one cycle in five unless calm
    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
    end

    function automatic void note_mismatch(string what, pixel_t want);
        err_count++;
        if (err_count <= SHOW_LIMIT)
            $display("MISMATCH %s: expected rgb %02h %02h %02h degen %0b, got %02h %02h %02h degen %0b",
                     what, want.red, want.green, want.blue, want.degen,
                     m_pixel_red, m_pixel_green, m_pixel_blue, m_degenerate);
    endfunction

    // Check each transfer against the oldest answer owed; sampled mid-cycle
    always @(negedge aclk) begin : check_results
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (owed_pixels.size() == 0) begin
                want.red = '0;  want.green = '0;  want.blue = '0;  want.degen = 1'b0;
                note_mismatch("unexpected result", want);
            end else begin
                want = owed_pixels.pop_front();
                if (m_pixel_red !== want.red)
                    note_mismatch("pixel_red", want);
                if (m_pixel_green !== want.green)
                    note_mismatch("pixel_green", want);
                if (m_pixel_blue !== want.blue)
                    note_mismatch("pixel_blue", want);
                if (m_degenerate !== want.degen)
                    note_mismatch("degenerate", want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Frame must come up black after the clearing pass
    task automatic test_reset_black();
        push_command(make_read(0, 0));
        push_command(make_read(SCR_W - 1, SCR_H - 1));
    endtask

    // Two triangles in opposite windings; vertices sit on an edge and must be painted
    task automatic test_both_windings();
        push_command(make_fill(2, 2, 20, 4, 6, 18, 8'h12, 8'h34, 8'h56));
        push_command(make_read(8, 8));
        push_command(make_read(1, 1));
        push_command(make_read(2, 2));
        push_command(make_fill(36, 6, 44, 20, 56, 4, 8'hA5, 8'h5A, 8'hC3));
        push_command(make_read(45, 10));
        push_command(make_read(44, 20));
    endtask

    // Vertices at the coordinate limits; two halves cover the whole screen
    task automatic test_screen_extremes();
        push_command(make_fill(-2048, -2048, 2047, -2048, 2047, 2047, 8'hFF, 8'hFF, 8'hFF));
        push_command(make_fill(-2048, -2048, -2048, 2047, 2047, 2047, 8'hFF, 8'hFF, 8'hFF));
        push_command(make_read(0, SCR_H - 1));
        push_command(make_read(SCR_W - 1, 0));
        push_command(make_read(0, 0));
    endtask

    // Zero area: a line across pixels and a single point must write nothing
    task automatic test_zero_area();
        push_command(make_fill(0, 0, 10, 5, 20, 10, 8'hFF, 8'h00, 8'h00));
        push_command(make_read(10, 5));
        push_command(make_fill(5, 5, 5, 5, 5, 5, 8'h00, 8'hFF, 8'h00));
        push_command(make_read(5, 5));
    endtask

    // Box clamps to nothing: not degenerate, nothing written
    task automatic test_off_screen_box();
        push_command(make_fill(-30, -30, -5, -20, -10, -2, 8'h00, 8'h00, 8'hFF));
        push_command(make_fill(100, 5, 200, 5, 150, 40, 8'h00, 8'h00, 8'hFF));
        push_command(make_read(0, 0));
    endtask

    // Unused operation code with a busy payload
    task automatic test_unused_op();
        raster_cmd_t c;
        c = random_cmd();
        c.op = OP_NOP;
        push_command(c);
    endtask

    // Blacken a painted frame, then read back a pixel that was white
    task automatic test_clear_frame();
        raster_cmd_t c;
        c = make_read(0, 0);
        c.op = OP_CLEAR;
        push_command(c);
        push_command(make_read(8, 8));
    endtask

    task automatic test_random_mix(int count);
        repeat (count) push_command(random_cmd());
    endtask

    // Hold off the sender until every owed answer has arrived
    task automatic test_drain_pause();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (owed_pixels.size() != 0) @(posedge aclk);
        push_command(make_read($urandom_range(SCR_W - 1), $urandom_range(SCR_H - 1)));
    endtask

    initial begin : main_flow
        // the block wipes its store after reset, so the shadow starts black
        foreach (frame_px[i]) frame_px[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_black();
        test_both_windings();
        test_screen_extremes();
        test_zero_area();
        test_off_screen_box();
        test_unused_op();
        test_clear_frame();
        test_random_mix(100);
        // long stretch with both channels running flat out
        calm = 1'b1;
        test_random_mix(60);
        calm = 1'b0;
        test_drain_pause();
        test_random_mix(100);

        // stop sending, let the block drain, then watch for strays
        s_valid <= 1'b0;
        while (owed_pixels.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d clears, %0d fills (%0d zero-area), %0d reads, %0d unused ops",
                 n_clear, n_fill, n_degen, n_read, n_nop);
        $display("%0d results checked, %0d mismatches", n_results, err_count);
        if (err_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #20000000;
        $display("tb failed");
        $finish;
    end

endmodule
